// ===== rtl/awf_pkg.sv =====
// shared types and constants for the audio wavefolder
`timescale 1ns / 1ps
`default_nettype none

package awf_pkg;

    localparam int IO_WIDTH   = 23;
    localparam int TDATA_W    = 24;
    localparam int TRIM_W     = 18;
    localparam int GAIN_W     = 16;
    localparam int ADDR_W     = 5;
    localparam int CTL_MIN    = 33;
    localparam int GAIN_ONE   = 32768;

    typedef enum logic [2:0] {
        REG_TRIM     = 3'd0,
        REG_FEEDBACK = 3'd1,
        REG_FEEDFWD  = 3'd2,
        REG_FOLDCTL  = 3'd3,
        REG_FOLDMODE = 3'd4
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PHASE,
        ST_FOLD,
        ST_FOLDW,
        ST_TRIM,
        ST_ACC1,
        ST_FF,
        ST_ACC2,
        ST_FB,
        ST_FBIDX,
        ST_TANHW,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/audio_wavefolder_feedback_unit.sv =====
// top level of the audio wavefolder with feedforward and feedback paths
//
//  channel | ports            | payload
//  input   | s_tvalid/tready  | s_tdata[22:0] sample_in, Q3.20 signed
//  output  | m_tvalid/tready  | m_tdata[22:0] sample_out, Q3.20 signed, saturated
//  config  | apb psel/penable | five registers at byte address 4*index
//
// a request is taken in idle and its result is registered after the phase, fold,
// trim, feedforward and feedback steps; the next request is taken back in idle, as
// the sequencer drives one shared multiplier four times and the table port three times.
// s_tready is high only while the sequencer is idle; the result waits in an
// output register, and the final step holds while that register is still full.
// aresetn resets the configuration to its defaults and clears the feedback state and the handshakes.
`timescale 1ns / 1ps
`default_nettype none

module audio_wavefolder_feedback_unit
    import awf_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 24,
    parameter int FRAC_BITS    = 20,
    parameter int TABLE_DEPTH  = 1024
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [TDATA_W-1:0] s_tdata,   // [22:0] sample_in, [23] zero
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,   // [22:0] sample_out, [23] zero
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [ADDR_W-1:0]  paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int AW   = $clog2(TABLE_DEPTH);
    localparam int PB   = FRAC_BITS + 16;
    localparam int FW   = FRAC_BITS + 2;
    localparam int MA0  = (IO_WIDTH > SAMPLE_WIDTH) ? IO_WIDTH : SAMPLE_WIDTH;
    localparam int MA   = (MA0 > FRAC_BITS + 1) ? MA0 : FRAC_BITS + 1;
    localparam int MB   = TRIM_W;
    localparam int PW   = MA + MB;
    localparam int ACCW = FRAC_BITS + 5;
    localparam int TMW  = MA0;
    localparam int TS   = FRAC_BITS + 3 - AW;
    localparam int EW0  = (ACCW > MA0) ? ACCW : MA0;
    localparam int EW   = EW0 + 1;

    // configuration registers
    logic signed [TRIM_W-1:0] trim_reg;
    logic [GAIN_W-1:0]        fb_gain_reg, ff_gain_reg, fold_ctl_reg;
    logic                     fold_mode_reg;
    logic                     wr_en;
    reg_idx_t                 wr_idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign wr_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trim_reg      <= TRIM_W'(16384);
            fb_gain_reg   <= '0;
            ff_gain_reg   <= '0;
            fold_ctl_reg  <= GAIN_W'(16384);
            fold_mode_reg <= 1'b0;
        end else if (wr_en) begin
            case (wr_idx)
                REG_TRIM:     trim_reg      <= pwdata[TRIM_W-1:0];
                REG_FEEDBACK: fb_gain_reg   <= pwdata[GAIN_W-1:0];
                REG_FEEDFWD:  ff_gain_reg   <= pwdata[GAIN_W-1:0];
                REG_FOLDCTL:  fold_ctl_reg  <= pwdata[GAIN_W-1:0];
                REG_FOLDMODE: fold_mode_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (wr_idx)
            REG_TRIM:     prdata = {{(32-TRIM_W){1'b0}}, trim_reg};
            REG_FEEDBACK: prdata = {16'd0, fb_gain_reg};
            REG_FEEDFWD:  prdata = {16'd0, ff_gain_reg};
            REG_FOLDCTL:  prdata = {16'd0, fold_ctl_reg};
            REG_FOLDMODE: prdata = {31'd0, fold_mode_reg};
            default:      prdata = '0;
        endcase
    end

    // clamped controls
    logic [GAIN_W-1:0] ctl_c, fb_c, ff_c;
    logic [MB-1:0]     trim_mag;
    always_comb begin
        if (fold_ctl_reg < GAIN_W'(CTL_MIN)) begin
            ctl_c = GAIN_W'(CTL_MIN);
        end else if (fold_ctl_reg > GAIN_W'(GAIN_ONE)) begin
            ctl_c = GAIN_W'(GAIN_ONE);
        end else begin
            ctl_c = fold_ctl_reg;
        end
        fb_c     = (fb_gain_reg > GAIN_W'(GAIN_ONE)) ? GAIN_W'(GAIN_ONE) : fb_gain_reg;
        ff_c     = (ff_gain_reg > GAIN_W'(GAIN_ONE)) ? GAIN_W'(GAIN_ONE) : ff_gain_reg;
        trim_mag = trim_reg[TRIM_W-1] ? MB'(-trim_reg) : MB'(trim_reg);
    end

    // datapath registers
    state_t                   state_reg, state_next;
    logic [IO_WIDTH-1:0]      x_reg;
    logic [PW-1:0]            mul_reg;
    logic signed [FW-1:0]     fold_reg;
    logic [FW-2:0]            tx_reg;
    logic signed [ACCW-1:0]   acc_reg;
    logic signed [SAMPLE_WIDTH-1:0] last_reg;
    logic [IO_WIDTH-1:0]      out_reg;
    logic                     m_valid_reg;

    logic                     x_neg, last_neg;
    logic [IO_WIDTH-1:0]      x_mag;
    logic [SAMPLE_WIDTH-1:0]  last_mag;
    logic [FW-2:0]            fold_mag;
    logic signed [FW-1:0]     rom_data;

    assign x_neg    = x_reg[IO_WIDTH-1];
    assign last_neg = last_reg[SAMPLE_WIDTH-1];
    assign x_mag    = x_neg ? (-x_reg) : x_reg;
    assign last_mag = last_neg ? SAMPLE_WIDTH'(-last_reg) : SAMPLE_WIDTH'(last_reg);
    assign fold_mag = fold_reg[FW-1] ? (FW-1)'(-fold_reg) : (FW-1)'(fold_reg);

    // phase and triangle fold
    logic [PB-1:0]        phase_low, tri_w, tri_md;
    logic signed [FW-1:0] tri_fold;
    always_comb begin
        phase_low = x_neg ? (-mul_reg[PB-1:0]) : mul_reg[PB-1:0];
        tri_w     = phase_low + (PB'(3) << (PB - 2));
        tri_md    = tri_w[PB-1] ? (tri_w - (PB'(1) << (PB - 1)))
                                : ((PB'(1) << (PB - 1)) - tri_w);
        tri_fold  = FW'(tri_md >> (PB - FRAC_BITS - 2)) - (FW'(1) << FRAC_BITS);
    end

    // shared multiplier operand select and table address
    logic [MA-1:0]  mul_a;
    logic [MB-1:0]  mul_b;
    logic [TMW-1:0] tanh_mag, tanh_sh;
    logic [AW-1:0]  tanh_idx, rom_addr;
    logic           rom_tanh;

    always_comb begin
        tanh_mag = (state_reg == ST_FBIDX) ? TMW'(mul_reg >> 15) : TMW'(x_mag);
        tanh_sh  = tanh_mag >> TS;
        tanh_idx = (tanh_sh > TMW'(TABLE_DEPTH - 1)) ? AW'(TABLE_DEPTH - 1)
                                                    : tanh_sh[AW-1:0];
    end

    always_comb begin
        mul_a    = MA'(x_mag);
        mul_b    = MB'(ctl_c);
        rom_addr = tanh_idx;
        rom_tanh = 1'b1;
        case (state_reg)
            ST_PHASE: begin
                mul_a = MA'(x_mag);
                mul_b = MB'(ctl_c);
            end
            ST_FOLD: begin
                rom_addr = phase_low[PB-1 -: AW];
                rom_tanh = 1'b0;
            end
            ST_TRIM: begin
                mul_a = MA'(fold_mag);
                mul_b = trim_mag;
            end
            ST_FF: begin
                mul_a = MA'(tx_reg);
                mul_b = MB'(ff_c);
            end
            ST_FB: begin
                mul_a = MA'(last_mag);
                mul_b = MB'(fb_c);
            end
            default: ;
        endcase
    end

    awf_rom #(
        .FRAC_BITS   (FRAC_BITS),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_rom (
        .aclk     (aclk),
        .tanh_sel (rom_tanh),
        .addr     (rom_addr),
        .data     (rom_data)
    );

    // sequencer
    logic out_free;
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_PHASE;
            ST_PHASE: state_next = ST_FOLD;
            ST_FOLD:  state_next = ST_FOLDW;
            ST_FOLDW: state_next = ST_TRIM;
            ST_TRIM:  state_next = ST_ACC1;
            ST_ACC1:  state_next = ST_FF;
            ST_FF:    state_next = ST_ACC2;
            ST_ACC2:  state_next = ST_FB;
            ST_FB:    state_next = ST_FBIDX;
            ST_FBIDX: state_next = ST_TANHW;
            ST_TANHW: state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // accumulation terms
    logic [ACCW-1:0]        t_trim, t_ff;
    logic signed [ACCW-1:0] t_fb;
    logic signed [EW-1:0]   acc_ext, sw_hi, sw_lo, io_hi, io_lo, sat_sw, sat_io;

    always_comb begin
        t_trim  = ACCW'(mul_reg >> 14);
        t_ff    = ACCW'(mul_reg >> 15);
        t_fb    = ACCW'(rom_data);
        acc_ext = EW'(acc_reg);
        sw_hi   = (EW'(1) <<< (SAMPLE_WIDTH - 1)) - EW'(1);
        sw_lo   = -sw_hi - EW'(1);
        io_hi   = (EW'(1) <<< (IO_WIDTH - 1)) - EW'(1);
        io_lo   = -io_hi - EW'(1);
        sat_sw  = (acc_ext > sw_hi) ? sw_hi : ((acc_ext < sw_lo) ? sw_lo : acc_ext);
        sat_io  = (acc_ext > io_hi) ? io_hi : ((acc_ext < io_lo) ? io_lo : acc_ext);
    end

    always_ff @(posedge aclk) begin
        mul_reg <= mul_a * mul_b;
        case (state_reg)
            ST_IDLE:  if (s_tvalid) x_reg <= s_tdata[IO_WIDTH-1:0];
            ST_FOLD:  fold_reg <= tri_fold;
            ST_FOLDW: if (!fold_mode_reg) fold_reg <= rom_data;
            ST_TRIM:  tx_reg <= rom_data[FW-2:0];
            ST_ACC1:  acc_reg <= (fold_reg[FW-1] ^ trim_reg[TRIM_W-1]) ? -t_trim : t_trim;
            ST_ACC2:  acc_reg <= acc_reg + (x_neg ? -t_ff : t_ff);
            ST_TANHW: acc_reg <= acc_reg + (last_neg ? -t_fb : t_fb);
            ST_DONE:  if (out_free) out_reg <= sat_io[IO_WIDTH-1:0];
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && out_free) begin
            last_reg    <= sat_sw[SAMPLE_WIDTH-1:0];
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(TDATA_W-IO_WIDTH){1'b0}}, out_reg};

endmodule

`default_nettype wire

// ===== rtl/awf_rom.sv =====
// sine and tanh lookup tables with registered read
`timescale 1ns / 1ps
`default_nettype none

module awf_rom #(
    parameter int FRAC_BITS   = 20,
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic                           aclk,
    input  wire logic                           tanh_sel,
    input  wire logic [$clog2(TABLE_DEPTH)-1:0] addr,
    output logic signed [FRAC_BITS+1:0]         data
);

    localparam int FW = FRAC_BITS + 2;
    localparam longint unsigned Q28_ONE   = 64'd1 << 28;
    localparam longint unsigned Q30_ONE   = 64'd1 << 30;
    localparam longint unsigned HALF_PI   = 64'd421657428;
    localparam longint unsigned INV_E_Q30 = 64'd395007542;

    typedef logic signed [FW-1:0] rom_t [TABLE_DEPTH];

    // shift and subtract quotient, only used while the tables are built
    function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
        longint unsigned quo, rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], num[i]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic longint unsigned round_frac(longint unsigned v, int from);
        int sh;
        sh = from - FRAC_BITS;
        if (sh == 0) begin
            return v;
        end
        return (v + (64'd1 << (sh - 1))) >> sh;
    endfunction

    function automatic longint unsigned quarter_sine(longint unsigned num);
        longint unsigned a, x2, t, dv;
        a  = HALF_PI * num / TABLE_DEPTH;
        x2 = (a * a) >> 28;
        t  = Q28_ONE;
        for (int n = 7; n >= 1; n--) begin
            dv = 64'((2 * n) * (2 * n + 1));
            t  = Q28_ONE - udiv((x2 * t) >> 28, dv);
        end
        t = (a * t) >> 28;
        return (t > Q28_ONE) ? Q28_ONE : t;
    endfunction

    function automatic rom_t build_sine();
        rom_t tab;
        longint unsigned q, r, s, v;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            q = (64'd4 * 64'(k)) / TABLE_DEPTH;
            r = (64'd4 * 64'(k)) % TABLE_DEPTH;
            s = q[0] ? quarter_sine(64'(TABLE_DEPTH) - r) : quarter_sine(r);
            v = round_frac(s, 28);
            tab[k] = (q >= 2) ? -FW'(v) : FW'(v);
        end
        return tab;
    endfunction

    function automatic rom_t build_tanh();
        rom_t tab;
        longint unsigned num, n, f, z, dv;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            num = 64'd16 * 64'(k);
            n   = num / TABLE_DEPTH;
            f   = ((num % TABLE_DEPTH) << 30) / TABLE_DEPTH;
            z   = Q30_ONE;
            for (int m = 12; m >= 1; m--) begin
                dv = 64'(m);
                z  = Q30_ONE - udiv((f * z) >> 30, dv);
            end
            for (longint unsigned j = 0; j < n; j++) begin
                z = (z * INV_E_Q30) >> 30;
            end
            tab[k] = FW'(round_frac(udiv((Q30_ONE - z) << 30, Q30_ONE + z), 30));
        end
        return tab;
    endfunction

    localparam rom_t SINE_ROM = build_sine();
    localparam rom_t TANH_ROM = build_tanh();

    always_ff @(posedge aclk) begin
        data <= tanh_sel ? TANH_ROM[addr] : SINE_ROM[addr];
    end

endmodule

`default_nettype wire

// ===== test/awf_checker.sv =====
// scoreboard for the wavefolder: tracks config writes, predicts each sample, compares results
`timescale 1ns / 1ps

module awf_checker
    import awf_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    input  wire logic               s_tready,
    input  wire logic [TDATA_W-1:0] s_tdata,
    input  wire logic               m_tvalid,
    input  wire logic               m_tready,
    input  wire logic [TDATA_W-1:0] m_tdata,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [ADDR_W-1:0]  paddr,
    input  wire logic [31:0]        pwdata,
    input  wire logic               pready,
    output int                      fail_count,
    output int                      pending
);

    localparam int FRAC = 20;
    localparam int DEPTH = 1024;
    localparam longint unsigned Q28 = 64'd1 << 28;
    localparam longint unsigned Q30 = 64'd1 << 30;
    localparam longint unsigned PMASK = (64'd1 << 36) - 64'd1;

    longint sine_lut [DEPTH];
    longint tanh_lut [DEPTH];

    longint          trim;
    longint unsigned fb_gain, ff_gain, fold_ctl, fold_tri;
    longint          fed_back;
    logic [IO_WIDTH-1:0] folded_q [$];

    function automatic longint unsigned round_to_frac(longint unsigned v, int from);
        int sh;
        sh = from - FRAC;
        return (v + (64'd1 << (sh - 1))) >> sh;
    endfunction

    // sin(pi/2 * num/DEPTH) in Q28
    function automatic longint unsigned quarter_wave(longint unsigned num);
        longint unsigned a, x2, t, n;
        a = 64'd421657428 * num / DEPTH;
        x2 = (a * a) >> 28;
        t = Q28;
        for (n = 7; n >= 1; n--)
            t = Q28 - ((x2 * t) >> 28) / ((2 * n) * (2 * n + 1));
        t = (a * t) >> 28;
        return t > Q28 ? Q28 : t;
    endfunction

    initial begin
        longint unsigned k, q, r, s, num, whole, f, z, m;
        for (k = 0; k < DEPTH; k++) begin
            q = (4 * k) / DEPTH;
            r = (4 * k) % DEPTH;
            s = q[0] ? quarter_wave(DEPTH - r) : quarter_wave(r);
            sine_lut[k] = (q >= 2) ? -longint'(round_to_frac(s, 28))
                                   : longint'(round_to_frac(s, 28));
        end
        for (k = 0; k < DEPTH; k++) begin
            num = 16 * k;
            whole = num / DEPTH;
            f = ((num % DEPTH) << 30) / DEPTH;
            z = Q30;
            for (m = 12; m >= 1; m--)
                z = Q30 - ((f * z) >> 30) / m;
            for (m = 0; m < whole; m++)
                z = (z * 64'd395007542) >> 30;
            tanh_lut[k] = longint'(round_to_frac(((Q30 - z) << 30) / (Q30 + z), 30));
        end
    end

    function automatic longint scale_mag(longint a, longint b, int sh);
        longint unsigned ma, mb, p;
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        p = (ma * mb) >> sh;
        return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint soft_clip(longint x);
        longint unsigned mag, idx;
        mag = x < 0 ? -x : x;
        idx = (mag * DEPTH) >> (FRAC + 3);
        if (idx > DEPTH - 1)
            idx = DEPTH - 1;
        return x < 0 ? -tanh_lut[idx] : tanh_lut[idx];
    endfunction

    function automatic longint clamp_to(longint v, int w);
        longint hi;
        hi = (longint'(1) << (w - 1)) - 1;
        return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
    endfunction

    function automatic logic [IO_WIDTH-1:0] fold_sample(logic signed [IO_WIDTH-1:0] x_in);
        longint x, ctl, fb, ff, ph, d, fold, total;
        longint unsigned w, md;
        x = x_in;
        ctl = fold_ctl < CTL_MIN ? CTL_MIN : (fold_ctl > GAIN_ONE ? GAIN_ONE : fold_ctl);
        fb = fb_gain > GAIN_ONE ? GAIN_ONE : fb_gain;
        ff = ff_gain > GAIN_ONE ? GAIN_ONE : ff_gain;
        ph = x * ctl;
        if (fold_tri != 0) begin
            w = (longint'(ph) + (64'd1 << 34) + (64'd1 << 35)) & PMASK;
            d = longint'(w) - longint'(64'd1 << 35);
            md = d < 0 ? -d : d;
            fold = longint'(md >> 14) - (longint'(1) << FRAC);
        end else begin
            fold = sine_lut[((longint'(ph) & PMASK) * DEPTH) >> 36];
        end
        total = scale_mag(fold, trim, 14);
        total += scale_mag(soft_clip(x), ff, 15);
        total += soft_clip(scale_mag(fed_back, fb, 15));
        fed_back = clamp_to(total, 24);
        return IO_WIDTH'(clamp_to(total, IO_WIDTH));
    endfunction

    task automatic report(string what, logic [IO_WIDTH-1:0] want, logic [IO_WIDTH-1:0] got);
        $display("mismatch %s: expected %0d got %0d at %0t", what,
                 $signed(want), $signed(got), $realtime);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        logic [IO_WIDTH-1:0] want;
        if (!aresetn) begin
            trim = 16384;
            fb_gain = 0;
            ff_gain = 0;
            fold_ctl = 16384;
            fold_tri = 0;
            fed_back = 0;
            folded_q.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
                case (paddr[ADDR_W-1:2])
                    REG_TRIM:     trim = longint'($signed(pwdata[TRIM_W-1:0]));
                    REG_FEEDBACK: fb_gain = pwdata[15:0];
                    REG_FEEDFWD:  ff_gain = pwdata[15:0];
                    REG_FOLDCTL:  fold_ctl = pwdata[15:0];
                    REG_FOLDMODE: fold_tri = pwdata[0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (folded_q.size() == 0) begin
                    report("unexpected sample", '0, m_tdata[IO_WIDTH-1:0]);
                end else begin
                    want = folded_q.pop_front();
                    if (m_tdata[IO_WIDTH-1:0] !== want)
                        report("sample_out", want, m_tdata[IO_WIDTH-1:0]);
                end
            end
            if (s_tvalid && s_tready)
                folded_q.push_back(fold_sample(s_tdata[IO_WIDTH-1:0]));
        end
        pending = folded_q.size();
    end

    initial begin
        fail_count = 0;
        pending = 0;
    end

endmodule

// ===== test/tb_audio_wavefolder_feedback_unit.sv =====
// testbench top for the audio wavefolder: stimulus, config writes and verdict
`timescale 1ns / 1ps

module tb_audio_wavefolder_feedback_unit;
    import awf_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    logic aclk = 0, aresetn = 0;
    logic s_tvalid = 0, m_tready = 0;
    logic [TDATA_W-1:0] s_tdata = '0;
    logic s_tready, m_tvalid;
    logic [TDATA_W-1:0] m_tdata;
    logic psel = 0, penable = 0, pwrite = 0, pready;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0, prdata;
    int fail_count, pending;
    int cycles = 0;
    int hold_start = -1;

    always #6 aclk = ~aclk;

    audio_wavefolder_feedback_unit uut (.*);

    awf_checker chk (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: a random stall pattern from four styles, redrawn periodically, plus one long hold-off
    initial begin
        int style, n;
        style = 0;
        n = 0;
        forever begin
            @(negedge aclk);
            if (n % 64 == 0)
                style = $urandom_range(0, 3);
            n++;
            if (hold_start >= 0 && n - hold_start < 400 && n >= hold_start)
                m_tready = 1'b0;
            else if (style == 0)
                m_tready = 1'b1;
            else if (style == 1)
                m_tready = ($urandom_range(0, 3) != 0);
            else if (style == 2)
                m_tready = ($urandom_range(0, 3) == 0);
            else
                m_tready = 1'($urandom_range(0, 1));
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        @(negedge aclk);
        psel = 1;
        pwrite = 1;
        penable = 0;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge aclk);
        penable = 1;
        @(negedge aclk);
        psel = 0;
        penable = 0;
        pwrite = 0;
    endtask

    task automatic wait_drained;
        while (pending != 0)
            @(negedge aclk);
        repeat (30) @(negedge aclk);
    endtask

    // offers one request and returns at the negedge after it was taken
    task automatic push_sample(logic [IO_WIDTH-1:0] v, bit keep_valid);
        logic taken;
        s_tvalid = 1;
        s_tdata = {1'b0, v};
        do begin
            #1 taken = s_tready;
            @(negedge aclk);
        end while (!taken);
        if (!keep_valid)
            s_tvalid = 0;
    endtask

    function automatic logic [IO_WIDTH-1:0] random_sample();
        case ($urandom_range(0, 5))
            0: return IO_WIDTH'($urandom_range(0, 31) - 16);
            1: return IO_WIDTH'($urandom_range(0, 2097152) - 1048576);
            2: return $urandom_range(0, 1) ? 23'h3FFFFF : 23'h400000;
            default: return IO_WIDTH'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] random_gain();
        case ($urandom_range(0, 4))
            0: return 16'd0;
            1: return 16'(GAIN_ONE);
            2: return 16'($urandom_range(32769, 65535));
            default: return 16'($urandom_range(0, GAIN_ONE));
        endcase
    endfunction

    task automatic random_phase(int count);
        int burst, gap;
        while (count > 0) begin
            burst = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
            for (int i = 0; i < burst && count > 0; i++) begin
                count--;
                push_sample(random_sample(), i < burst - 1 && count > 0);
            end
            repeat (gap) @(negedge aclk);
        end
    endtask

    initial begin
        logic [IO_WIDTH-1:0] corner [16];
        corner = '{23'h000000, 23'h000001, 23'h7FFFFF, 23'h3FFFFF, 23'h400000,
                   23'h100000, 23'h700000, 23'h080000, 23'h780000, 23'h040000,
                   23'h200000, 23'h600000, 23'h155555, 23'h2AAAAA, 23'h0FFFFF,
                   23'h000800};
        repeat (6) @(negedge aclk);
        aresetn = 1;
        repeat (2) @(negedge aclk);

        // reset settings, then triangle, then sine with out-of-range controls, all with extreme samples
        foreach (corner[i]) push_sample(corner[i], 0);
        wait_drained();
        write_reg(REG_FOLDMODE, 1);
        write_reg(REG_FEEDFWD, GAIN_ONE);
        write_reg(REG_FEEDBACK, 16'hFFFF);
        write_reg(REG_TRIM, 32'h0001FFFF);
        write_reg(REG_FOLDCTL, 0);
        foreach (corner[i]) push_sample(corner[i], 0);
        wait_drained();
        write_reg(REG_TRIM, 32'hFFFE0000);
        write_reg(REG_FOLDCTL, 16'hFFFF);
        write_reg(REG_FOLDMODE, 0);
        write_reg(reg_idx_t'(3'd6), 32'h12345678);
        for (int i = 0; i < 6; i++) push_sample(corner[i + 1], 0);
        wait_drained();

        for (int p = 0; p < 8; p++) begin
            write_reg(REG_TRIM, (p == 1) ? 32'h0001FFFF : (p == 2) ? 32'h00020000 : $urandom);
            write_reg(REG_FEEDBACK, 32'(random_gain()));
            write_reg(REG_FEEDFWD, 32'(random_gain()));
            write_reg(REG_FOLDCTL, (p == 3) ? 16'd32 : (p == 4) ? 16'd33 : $urandom);
            write_reg(REG_FOLDMODE, p[0]);
            if (p == 5) begin
                @(negedge aclk);
                hold_start = cycles + 20;
            end
            random_phase(220);
            wait_drained();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/awf_pkg.sv
rtl/awf_rom.sv
rtl/audio_wavefolder_feedback_unit.sv
test/awf_checker.sv
test/tb_audio_wavefolder_feedback_unit.sv
